[hdl/slq_pkg.sv]
// slq_pkg: shared constants, operation codes and the control struct of the
// sorted list queue. No dependencies.

package slq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [1:0] FN_SORTED = 2'd0;
    localparam logic [1:0] FN_FRONT  = 2'd1;
    localparam logic [1:0] FN_END    = 2'd2;
    localparam logic [1:0] FN_POP    = 2'd3;

    typedef struct packed {
        logic       ins;   // insert that is carried out (list not full)
        logic       pop;   // pop that removes an entry (list not empty)
        logic [1:0] func;
    } t_ctl;

endpackage

[hdl/slq_cell.sv]
// slq_cell: one slot of the list. Holds an entry, finds the insert point
// with its neighbors and shifts right on insert, left on pop. Uses slq_pkg.

module slq_cell (
    input  logic                        i_clk,
    input  slq_pkg::t_ctl               i_ctl,
    input  logic signed [31:0]          i_value,
    input  logic                        i_occ,
    input  logic                        i_first,
    input  logic signed [31:0]          i_left_val,
    input  logic                        i_left_past,
    input  logic signed [31:0]          i_right_val,
    output logic signed [31:0]          o_val,
    output logic                        o_past
);

    logic signed [31:0] r_val;
    logic signed [31:0] n_val;
    logic               v_lt_e;
    logic               e_lt_v;
    logic               hit;
    logic               at;

    assign v_lt_e = i_value < r_val;
    assign e_lt_v = r_val < i_value;

    // hit: insert point lies at or before this slot
    always_comb begin
        case (i_ctl.func)
            slq_pkg::FN_SORTED: hit = !i_occ || (i_first ? v_lt_e : !e_lt_v);
            slq_pkg::FN_FRONT:  hit = 1'b1;
            slq_pkg::FN_END:    hit = !i_occ;
            default:            hit = 1'b0;
        endcase
    end

    assign at     = hit && !i_left_past;
    assign o_past = hit || i_left_past;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (at) begin
                n_val = i_value;
            end else if (i_left_past) begin
                n_val = i_left_val;
            end
        end else if (i_ctl.pop) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

[hdl/sorted_list_queue.sv]
// sorted_list_queue: top level, a row of slq_cell slots plus the entry count
// and the result register. Depends on slq_pkg and slq_cell.
//
// Usage:
//   Request channel: drive i_func and i_value and raise start; a request is
//   taken at every rising edge where start is high and busy is low. busy
//   stays low: the cell row finishes one request per clock, so requests may
//   come back to back at one per cycle.
//   Result channel: o_strobe is high for exactly one cycle, the cycle after
//   the request was taken, with o_popped_value, o_was_empty,
//   o_refused and o_entry_count valid in that cycle. The receiver cannot
//   stall; every request yields exactly one result.
//   Operations: sorted insert, push front, push end and pop front. Each
//   slot compares its entry with the new value at once; the first slot that
//   accepts the value is found by a carry passed along the row, then slots
//   at and after it shift right. A pop shifts every slot left.
//   A full list refuses any insert (o_refused); a pop on an empty list
//   returns 0 with o_was_empty.
//   Reset (i_rst_n low, synchronous): empty the list and drop any pending
//   result. Entry storage is not cleared; only the count tells which slots
//   hold data.

module sorted_list_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic signed [31:0]          i_value,
    output logic                        o_strobe,
    output logic signed [31:0]          o_popped_value,
    output logic                        o_was_empty,
    output logic                        o_refused,
    output logic [slq_pkg::CNT_W-1:0]   o_entry_count
);

    localparam int N = slq_pkg::CAPACITY;
    localparam int W = slq_pkg::CNT_W;

    logic [W-1:0]        r_held;
    logic [W-1:0]        n_held;
    logic                r_strobe;
    logic signed [31:0]  r_popped;
    logic                r_empty;
    logic                r_refused;

    logic                take;
    logic                is_pop;
    logic                full;
    logic                empty;
    slq_pkg::t_ctl       ctl;

    logic signed [31:0]  cell_val  [N];
    logic                cell_past [N];
    logic [N-1:0]        occ;

    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign is_pop = i_func == slq_pkg::FN_POP;
    assign full  = r_held == W'(N);
    assign empty = r_held == '0;

    assign ctl = '{ins:  take && !is_pop && !full,
                   pop:  take && is_pop && !empty,
                   func: i_func};

    // occupancy: slot i holds data when i < count
    generate
        for (genvar gi = 0; gi < N; gi++) begin : g_cell
            logic signed [31:0] left_val;
            logic               left_past;
            logic signed [31:0] right_val;

            assign occ[gi] = W'(gi) < r_held;

            if (gi == 0) begin : g_head
                assign left_val  = '0;
                assign left_past = 1'b0;
            end else begin : g_link
                assign left_val  = cell_val[gi-1];
                assign left_past = cell_past[gi-1];
            end

            if (gi == N - 1) begin : g_tail
                assign right_val = '0;
            end else begin : g_next
                assign right_val = cell_val[gi+1];
            end

            slq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_value     (i_value),
                .i_occ       (occ[gi]),
                .i_first     (gi == 0),
                .i_left_val  (left_val),
                .i_left_past (left_past),
                .i_right_val (right_val),
                .o_val       (cell_val[gi]),
                .o_past      (cell_past[gi])
            );
        end
    endgenerate

    // advance the count by one on insert, drop it by one on pop
    always_comb begin
        n_held = r_held;
        if (ctl.ins) begin
            n_held = r_held + W'(1);
        end else if (ctl.pop) begin
            n_held = r_held - W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_held   <= n_held;
            r_strobe <= take;
        end
    end

    // result payload: hold the head entry on a real pop, else zero
    always_ff @(posedge i_clk) begin
        r_popped  <= ctl.pop ? cell_val[0] : '0;
        r_empty   <= is_pop && empty;
        r_refused <= !is_pop && full;
    end

    assign o_strobe       = r_strobe;
    assign o_popped_value = r_popped;
    assign o_was_empty    = r_empty;
    assign o_refused      = r_refused;
    assign o_entry_count  = r_held;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_strobe)
        else $error("request taken without a result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= W'(N))
        else $error("entry count beyond capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_was_empty |-> o_entry_count == '0 && o_popped_value == '0)
        else $error("empty pop with entries held");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_refused |-> o_entry_count == W'(N))
        else $error("refused insert while not full");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_held))
        else $error("count moved without a request");

endmodule

[bench/tb_sorted_list_queue.sv]
// tb_sorted_list_queue: self-checking bench for the sorted list queue, a directed table
// followed by biased random fill/drain traffic, all scored against a behavioral list.
// Depends on slq_pkg and sorted_list_queue.

module tb_sorted_list_queue;

    localparam int ITEMS      = 1300;     // random requests after the directed table
    localparam int CYCLE_MAX  = 100000;   // watchdog, many times the slowest legal run
    localparam int DRAIN_WAIT = 4;        // extra wait for stray results after the last owed one
    localparam int HOLD_AT    = 900;      // random request before which the sender waits dry
    localparam int CALM_LO    = 400;      // stretch of random requests sent back to back
    localparam int CALM_HI    = 700;

    localparam logic signed [slq_pkg::DATA_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic signed [slq_pkg::DATA_W-1:0] V_MAX = 32'sh7fff_ffff;

    // One result as the block reports it.
    typedef struct packed {
        logic signed [slq_pkg::DATA_W-1:0] popped;
        logic                              was_empty;
        logic                              refused;
        logic [slq_pkg::CNT_W-1:0]         count;
    } t_qres;

    // One directed row: the request, and where typed is set, the result written out by hand.
    typedef struct packed {
        logic [1:0]                        func;
        logic signed [slq_pkg::DATA_W-1:0] value;
        logic                              typed;
        logic signed [slq_pkg::DATA_W-1:0] popped;
        logic                              was_empty;
        logic                              refused;
        logic [slq_pkg::CNT_W-1:0]         count;
    } t_plan_row;

    localparam int PLAN_N = 24;

    // Walk from an empty list to a full one and back a little. Rows with typed = 0 are
    // scored by the list model only.
    //          func                value          typed popped empty refused count
    t_plan_row plan [PLAN_N] = '{
        '{slq_pkg::FN_POP,    32'sh0,          1, 0, 1, 0, 0 },  // pop on empty list
        '{slq_pkg::FN_SORTED, 32'sh0,          1, 0, 0, 0, 1 },  // first insert at front
        '{slq_pkg::FN_SORTED, V_MIN,           0, 0, 0, 0, 0 },  // below first entry
        '{slq_pkg::FN_SORTED, V_MAX,           0, 0, 0, 0, 0 },  // nothing larger: end
        '{slq_pkg::FN_SORTED, V_MIN,           0, 0, 0, 0, 0 },  // equal to first: after it
        '{slq_pkg::FN_SORTED, 32'sh0,          0, 0, 0, 0, 0 },  // equal later: before it
        '{slq_pkg::FN_FRONT,  32'sh5,          0, 0, 0, 0, 0 },
        '{slq_pkg::FN_SORTED, 32'sh3,          0, 0, 0, 0, 0 },  // below a pushed front
        '{slq_pkg::FN_SORTED, 32'sh4,          0, 0, 0, 0, 0 },  // scan starts at one
        '{slq_pkg::FN_END,    -32'sh1,         0, 0, 0, 0, 0 },
        '{slq_pkg::FN_POP,    32'sh0,          0, 0, 0, 0, 0 },
        '{slq_pkg::FN_FRONT,  32'sh5555_5555,  0, 0, 0, 0, 0 },
        '{slq_pkg::FN_END,    32'shaaaa_aaaa,  0, 0, 0, 0, 0 },
        '{slq_pkg::FN_SORTED, V_MAX,           0, 0, 0, 0, 0 },
        '{slq_pkg::FN_FRONT,  V_MIN,           0, 0, 0, 0, 0 },
        '{slq_pkg::FN_END,    32'sh1,          0, 0, 0, 0, 0 },
        '{slq_pkg::FN_SORTED, -32'sh1,         0, 0, 0, 0, 0 },
        '{slq_pkg::FN_FRONT,  32'sh0000_ffff,  0, 0, 0, 0, 0 },
        '{slq_pkg::FN_END,    32'shffff_0000,  0, 0, 0, 0, 0 },  // list now full
        '{slq_pkg::FN_SORTED, 32'sh7,          1, 0, 0, 1, 16},  // every insert refused
        '{slq_pkg::FN_FRONT,  32'sh7,          1, 0, 0, 1, 16},
        '{slq_pkg::FN_END,    32'sh7,          1, 0, 0, 1, 16},
        '{slq_pkg::FN_POP,    32'sh0,          0, 0, 0, 0, 0 },
        '{slq_pkg::FN_POP,    32'sh0,          0, 0, 0, 0, 0 }
    };

    // Drive every input to a known level from time zero.
    logic                              i_clk   = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start   = 1'b0;
    logic [1:0]                        i_func  = slq_pkg::FN_SORTED;
    logic signed [slq_pkg::DATA_W-1:0] i_value = '0;
    logic                              busy;
    logic                              o_strobe;
    logic signed [slq_pkg::DATA_W-1:0] o_popped_value;
    logic                              o_was_empty;
    logic                              o_refused;
    logic [slq_pkg::CNT_W-1:0]         o_entry_count;

    sorted_list_queue uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_popped_value (o_popped_value),
        .o_was_empty    (o_was_empty),
        .o_refused      (o_refused),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Behavioral copy of the list: only the first list_len slots hold data.
    logic signed [slq_pkg::DATA_W-1:0] list_model [slq_pkg::CAPACITY];
    int                                list_len = 0;

    t_qres pending_q [$];   // results owed by the block, oldest first
    int    errors    = 0;
    int    cycles    = 0;
    bit    idle_on   = 1'b1;

    int n_sent = 0, n_pops = 0, n_empty = 0, n_refused = 0, n_full = 0;

    // Apply one request to the list model and return the result it must produce.
    function automatic t_qres list_apply(input logic [1:0] fn,
                                         input logic signed [slq_pkg::DATA_W-1:0] v);
        t_qres r;
        int    pos;
        int    i;
        r = '0;
        if (fn == slq_pkg::FN_POP) begin
            if (list_len == 0) begin
                r.was_empty = 1'b1;
            end else begin
                r.popped = list_model[0];
                for (i = 1; i < list_len; i++) list_model[i-1] = list_model[i];
                list_len--;
            end
        end else if (list_len >= slq_pkg::CAPACITY) begin
            r.refused = 1'b1;
        end else begin
            if (fn == slq_pkg::FN_FRONT) begin
                pos = 0;
            end else if (fn == slq_pkg::FN_END) begin
                pos = list_len;
            end else if (list_len == 0 || v < list_model[0]) begin
                pos = 0;
            end else begin
                // Past the front, stop at the first entry that is not smaller.
                pos = 1;
                while (pos < list_len && list_model[pos] < v) pos++;
            end
            for (i = list_len; i > pos; i--) list_model[i] = list_model[i-1];
            list_model[pos] = v;
            list_len++;
        end
        r.count = slq_pkg::CNT_W'(list_len);
        return r;
    endfunction

    // Send one request and wait for the handshake. With hold set, first wait until the
    // block owes nothing; otherwise idle now and then. Queue the expected result once taken.
    task automatic send_request(input logic [1:0] fn,
                                input logic signed [slq_pkg::DATA_W-1:0] v,
                                input bit hold, input bit typed, input t_qres typed_res);
        t_qres r;
        if (hold) begin
            if (pending_q.size() != 0) begin
                start <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
        end else if (idle_on && $urandom_range(0, 99) < 9) begin
            // Idle with junk on the payload so it is plainly ignored.
            start   <= 1'b0;
            i_func  <= 2'($urandom);
            i_value <= $urandom;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= fn;
        i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = list_apply(fn, v);
        pending_q.push_back(typed ? typed_res : r);
        n_sent++;
        if (fn == slq_pkg::FN_POP) n_pops++;
        if (r.was_empty) n_empty++;
        if (r.refused) n_refused++;
        if (r.count == slq_pkg::CNT_W'(slq_pkg::CAPACITY)) n_full++;
    endtask

    // Score each strobed result against the oldest expectation. Outputs are read at the
    // edge that ends the strobe cycle, before the block updates them.
    t_qres want;
    always @(posedge i_clk) begin
        if (o_strobe === 1'b1) begin
            if (pending_q.size() == 0) begin
                $display("%0t: result with no request pending: popped %0d count %0d",
                         $time, o_popped_value, o_entry_count);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (o_popped_value !== want.popped) begin
                    $display("%0t: popped_value expected %0d actual %0d",
                             $time, want.popped, o_popped_value);
                    errors++;
                end
                if (o_was_empty !== want.was_empty) begin
                    $display("%0t: was_empty expected %0b actual %0b",
                             $time, want.was_empty, o_was_empty);
                    errors++;
                end
                if (o_refused !== want.refused) begin
                    $display("%0t: refused expected %0b actual %0b",
                             $time, want.refused, o_refused);
                    errors++;
                end
                if (o_entry_count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.count, o_entry_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: give up if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("%0t: timeout, %0d results still owed", $time, pending_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [1:0]                        fn;
        logic signed [slq_pkg::DATA_W-1:0] v;
        t_qres                             t;
        int                                k;
        int                                n;
        int                                mode;
        int                                pop_pct;

        // Hold reset low from time zero, then release it once for good.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (k = 0; k < PLAN_N; k++) begin
            t.popped    = plan[k].popped;
            t.was_empty = plan[k].was_empty;
            t.refused   = plan[k].refused;
            t.count     = plan[k].count;
            send_request(plan[k].func, plan[k].value, 1'b0, plan[k].typed, t);
        end

        // Random traffic in segments biased to fill, drain or hover, so the list
        // keeps hitting both full and empty.
        n = 0;
        while (n < ITEMS) begin
            mode    = $urandom_range(0, 2);
            pop_pct = (mode == 0) ? 15 : (mode == 1) ? 65 : 40;
            repeat ($urandom_range(10, 60)) begin
                if ($urandom_range(0, 99) < pop_pct) begin
                    fn = slq_pkg::FN_POP;
                end else begin
                    case ($urandom_range(0, 3))
                        0, 1:    fn = slq_pkg::FN_SORTED;
                        2:       fn = slq_pkg::FN_FRONT;
                        default: fn = slq_pkg::FN_END;
                    endcase
                end
                // Mix extremes, a narrow band that makes ties common, and full-width values.
                case ($urandom_range(0, 7))
                    0: begin
                        case ($urandom_range(0, 3))
                            0:       v = V_MIN;
                            1:       v = V_MAX;
                            2:       v = '0;
                            default: v = -32'sh1;
                        endcase
                    end
                    1, 2, 3: v = $urandom_range(0, 20) - 10;
                    default: v = $urandom;
                endcase
                idle_on = !(n >= CALM_LO && n < CALM_HI);
                send_request(fn, v, n == HOLD_AT, 1'b0, '0);
                n++;
            end
        end
        start <= 1'b0;

        // Let every owed result arrive, then a few more cycles for strays.
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d requests: %0d pops (%0d on an empty list), %0d refused inserts,",
                 n_sent, n_pops, n_empty, n_refused);
        $display("%0d requests left the list full; %0d cycles in all.", n_full, cycles);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/slq_pkg.sv
hdl/slq_cell.sv
hdl/sorted_list_queue.sv
bench/tb_sorted_list_queue.sv
